@@ hw/rtl/lpfr_pkg.sv @@
`timescale 1ns / 1ps
package lpfr_pkg;
	localparam int CAPACITY = 4096;
	localparam int AW = $clog2(CAPACITY);
	localparam int OW = AW + 1;
	localparam int PREFIX = 4;
	localparam int QDEPTH = 2;

	typedef enum logic [1:0] {
		K_BEGIN_WR = 2'd0,
		K_WR_BYTE  = 2'd1,
		K_BEGIN_RD = 2'd2,
		K_RD_BYTE  = 2'd3
	} kind_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_DROP = 3'd1;
	localparam logic [2:0] ST_EMPTY = 3'd2;
	localparam logic [2:0] ST_NOFIT = 3'd3;
	localparam logic [2:0] ST_SEQ = 3'd4;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] frame_length;
		logic [7:0]  data_byte;
		logic [15:0] out_capacity;
	} item_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [11:0] read_length;
		logic [7:0]  read_byte;
		logic        last_byte;
		logic [12:0] used_bytes;
		logic [31:0] dropped_count;
	} result_t;

	// advance a ring position by one with wrap at the ring size
	function automatic logic [AW-1:0] adv1(input logic [AW-1:0] p, input logic [OW-1:0] rs);
		logic [OW-1:0] n;
		begin
			n = {1'b0, p} + OW'(1);
			if (n >= rs) n = '0;
			adv1 = n[AW-1:0];
		end
	endfunction
endpackage

@@ hw/rtl/length_prefixed_frame_ring_top.sv @@
`timescale 1ns / 1ps
// payload and error results are registered after the queue
// throughput: one payload write per cycle when the output is not stalled; read bytes
// (ram read port) and begin write/read (four prefix ram accesses) hold off new items
// reset: arst_n clears pointers, counts and open frames; ring_bytes returns to 4096
// a ring_bytes write empties the ring and keeps the drop count
module length_prefixed_frame_ring_top import lpfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] frame_length,
	input  logic [7:0]  data_byte,
	input  logic [15:0] out_capacity,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [11:0] read_length,
	output logic [7:0]  read_byte,
	output logic        last_byte,
	output logic [12:0] used_bytes,
	output logic [31:0] dropped_count,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [12:0] ring_q;
	logic [OW-1:0] rsize;
	logic wr, qv, qt;
	item_t qi;
	result_t res;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite && (paddr == 2'd0);
	assign prdata = {19'd0, ring_q};

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ring_q <= 13'(CAPACITY);
		else if (wr) ring_q <= pwdata[12:0];
	end

	// clamp ring size
	always_comb begin
		if (32'(ring_q) < 32'd8) rsize = OW'(8);
		else if (32'(ring_q) > 32'(CAPACITY)) rsize = OW'(CAPACITY);
		else rsize = OW'(ring_q);
	end

	lpfr_queue u_q (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item('{kind: kind, frame_length: frame_length, data_byte: data_byte,
			out_capacity: out_capacity}),
		.out_valid(qv), .out_take(qt), .out_item(qi)
	);

	lpfr_engine u_eng (
		.clk(clk), .arst_n(arst_n), .in_valid(qv), .in_take(qt), .in_item(qi),
		.rsize(rsize), .flush(wr), .out_valid(out_valid), .out_stall(out_stall),
		.out_res(res)
	);

	assign status = res.status;
	assign read_length = res.read_length;
	assign read_byte = res.read_byte;
	assign last_byte = res.last_byte;
	assign used_bytes = res.used_bytes;
	assign dropped_count = res.dropped_count;
endmodule

@@ hw/rtl/lpfr_ram.sv @@
`timescale 1ns / 1ps
module lpfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

@@ hw/rtl/lpfr_queue.sv @@
`timescale 1ns / 1ps
module lpfr_queue import lpfr_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	input  item_t in_item,
	output logic  out_valid,
	input  logic  out_take,
	output item_t out_item
);
	item_t slot_q [QDEPTH];
	logic [$clog2(QDEPTH)-1:0] wp_q, rp_q;
	logic [$clog2(QDEPTH):0] cnt_q;
	logic push, pop;

	assign in_stall = (cnt_q == ($clog2(QDEPTH)+1)'(QDEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item = slot_q[rp_q];
	assign push = in_valid && !in_stall;
	assign pop = out_valid && out_take;

	// item storage
	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= in_item;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end
endmodule

@@ hw/rtl/lpfr_engine.sv @@
`timescale 1ns / 1ps
module lpfr_engine import lpfr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_take,
	input  item_t         in_item,
	input  logic [OW-1:0] rsize,
	input  logic          flush,
	output logic          out_valid,
	input  logic          out_stall,
	output result_t       out_res
);
	typedef enum logic [3:0] {
		S_RUN  = 4'b0001,
		S_PW   = 4'b0010,
		S_PR   = 4'b0100,
		S_PEND = 4'b1000
	} state_t;

	state_t state_q;
	logic [2:0] step_q;
	logic [AW-1:0] woff_q, roff_q, wcur_q, rcur_q, pos_q;
	logic [OW-1:0] occ_q, wleft_q, rleft_q, wfr_q, rfr_q;
	logic wopen_q, ropen_q, rdpend_q;
	logic [31:0] drop_q;
	logic [15:0] flen_q, ocap_q;
	logic [31:0] len_q;
	logic ovalid_q;
	result_t res_q;

	logic we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0] wdata, rdata;

	lpfr_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	logic space;
	assign space = !ovalid_q || !out_stall;
	assign in_take = (state_q == S_RUN) && !rdpend_q && in_valid && space && !flush;
	assign out_valid = ovalid_q;
	assign out_res = res_q;

	logic [16:0] need;
	logic [OW-1:0] freeb;
	assign need = 17'(in_item.frame_length) + 17'(PREFIX);
	assign freeb = (occ_q < rsize) ? rsize - occ_q : '0;

	// memory ports
	always_comb begin
		we = 1'b0;
		waddr = wcur_q;
		wdata = in_item.data_byte;
		raddr = rcur_q;
		if (state_q == S_PW) begin
			we = 1'b1;
			waddr = pos_q;
			wdata = flen_q[7:0];
			if (step_q == 3'd1) wdata = flen_q[15:8];
			else if (step_q >= 3'd2) wdata = 8'd0;
		end else if (in_take && in_item.kind == K_WR_BYTE && wopen_q) begin
			we = 1'b1;
		end
		if (state_q == S_PR) raddr = pos_q;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RUN;
			step_q <= '0;
			woff_q <= '0; roff_q <= '0; wcur_q <= '0; rcur_q <= '0; pos_q <= '0;
			occ_q <= '0; wleft_q <= '0; rleft_q <= '0; wfr_q <= '0; rfr_q <= '0;
			wopen_q <= 1'b0; ropen_q <= 1'b0; rdpend_q <= 1'b0;
			drop_q <= '0; ovalid_q <= 1'b0;
			flen_q <= '0; ocap_q <= '0; len_q <= '0;
			res_q <= '0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			rdpend_q <= 1'b0;
			if (flush) begin
				state_q <= S_RUN;
				woff_q <= '0; roff_q <= '0; wcur_q <= '0; rcur_q <= '0;
				occ_q <= '0; wleft_q <= '0; rleft_q <= '0;
				wopen_q <= 1'b0; ropen_q <= 1'b0;
			end else begin
				unique case (state_q)
				S_RUN: begin
					// read byte result lands in the cycle after the access
					if (rdpend_q) begin
						res_q.read_byte <= rdata;
					end
					if (in_take) begin
						ovalid_q <= 1'b1;
						res_q <= '{status: ST_OK, read_length: '0, read_byte: '0,
							last_byte: 1'b0, used_bytes: occ_q, dropped_count: drop_q};
						unique case (kind_t'(in_item.kind))
						K_BEGIN_WR: begin
							if (wopen_q) res_q.status <= ST_SEQ;
							else if (need > 17'(rsize) || need > 17'(freeb)) begin
								res_q.status <= ST_DROP;
								if (drop_q != '1) begin
									drop_q <= drop_q + 1'b1;
									res_q.dropped_count <= drop_q + 1'b1;
								end
							end else begin
								ovalid_q <= 1'b0;
								flen_q <= in_item.frame_length;
								pos_q <= woff_q;
								step_q <= '0;
								state_q <= S_PW;
							end
						end
						K_WR_BYTE: begin
							if (!wopen_q) res_q.status <= ST_SEQ;
							else begin
								wcur_q <= adv1(wcur_q, rsize);
								wleft_q <= wleft_q - 1'b1;
								if (wleft_q == OW'(1)) begin
									woff_q <= adv1(wcur_q, rsize);
									occ_q <= occ_q + wfr_q + OW'(PREFIX);
									res_q.used_bytes <= occ_q + wfr_q + OW'(PREFIX);
									wopen_q <= 1'b0;
									res_q.last_byte <= 1'b1;
								end
							end
						end
						K_BEGIN_RD: begin
							if (ropen_q) res_q.status <= ST_SEQ;
							else if (occ_q < OW'(PREFIX)) res_q.status <= ST_EMPTY;
							else begin
								ovalid_q <= 1'b0;
								ocap_q <= in_item.out_capacity;
								pos_q <= roff_q;
								step_q <= '0;
								len_q <= '0;
								state_q <= S_PR;
							end
						end
						default: begin
							if (!ropen_q) res_q.status <= ST_SEQ;
							else begin
								ovalid_q <= 1'b0;
								rdpend_q <= 1'b1;
								state_q <= S_PEND;
								rcur_q <= adv1(rcur_q, rsize);
								rleft_q <= rleft_q - 1'b1;
								if (rleft_q == OW'(1)) begin
									roff_q <= adv1(rcur_q, rsize);
									occ_q <= occ_q - rfr_q - OW'(PREFIX);
									ropen_q <= 1'b0;
									res_q.last_byte <= 1'b1;
								end
							end
						end
						endcase
					end
				end
				S_PEND: begin
					// show read byte once output slot frees
					if (space) begin
						ovalid_q <= 1'b1;
						res_q.read_byte <= rdata;
						res_q.used_bytes <= occ_q;
						state_q <= S_RUN;
					end else rdpend_q <= 1'b0;
				end
				S_PW: begin
					// four prefix bytes, then open or publish
					pos_q <= adv1(pos_q, rsize);
					step_q <= step_q + 1'b1;
					if (step_q == 3'd3) begin
						wcur_q <= adv1(pos_q, rsize);
						wleft_q <= OW'(flen_q);
						wfr_q <= OW'(flen_q);
						if (space) begin
							ovalid_q <= 1'b1;
							state_q <= S_RUN;
							res_q <= '{status: ST_OK, read_length: '0, read_byte: '0,
								last_byte: (flen_q == '0),
								used_bytes: (flen_q == '0) ? occ_q + OW'(PREFIX) : occ_q,
								dropped_count: drop_q};
							if (flen_q == '0) begin
								woff_q <= adv1(pos_q, rsize);
								occ_q <= occ_q + OW'(PREFIX);
							end else wopen_q <= 1'b1;
						end else begin
							step_q <= step_q;
							pos_q <= pos_q;
						end
					end
				end
				S_PR: begin
					// read address issued at step, data in the cycle after
					if (step_q < 3'd4) pos_q <= adv1(pos_q, rsize);
					if (step_q != 3'd0 && step_q <= 3'd4)
						len_q[8*(step_q-3'd1) +: 8] <= rdata;
					step_q <= step_q + 1'b1;
					if (step_q == 3'd5) begin
						step_q <= step_q;
						if (space) begin
							ovalid_q <= 1'b1;
							state_q <= S_RUN;
							res_q <= '{status: ST_OK, read_length: '0, read_byte: '0,
								last_byte: 1'b0, used_bytes: occ_q, dropped_count: drop_q};
							if (33'(occ_q) < 33'(len_q) + 33'(PREFIX)
								|| 32'(ocap_q) < len_q) begin
								res_q.status <= ST_NOFIT;
							end else begin
								res_q.read_length <= len_q[11:0];
								rcur_q <= pos_q;
								rleft_q <= OW'(len_q);
								rfr_q <= OW'(len_q);
								if (len_q == '0) begin
									roff_q <= pos_q;
									occ_q <= occ_q - OW'(PREFIX);
									res_q.used_bytes <= occ_q - OW'(PREFIX);
									res_q.last_byte <= 1'b1;
								end else ropen_q <= 1'b1;
							end
						end
					end
				end
				default: state_q <= S_RUN;
				endcase
			end
		end
	end
endmodule

@@ hw/rtl/lpfr_checker.sv @@
`timescale 1ns / 1ps
module lpfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  status,
	input logic [12:0] used_bytes,
	input logic [31:0] dropped_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)) else $error("result dropped");
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= 3'd4) else $error("bad status");
	a_used: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_bytes <= 13'd4096) else $error("occupancy overflow");
	// drop count only moves up between results
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && $past(out_valid) |-> dropped_count >= $past(dropped_count))
		else $error("drop count went down");
endmodule

bind length_prefixed_frame_ring_top lpfr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .used_bytes(used_bytes), .dropped_count(dropped_count)
);

@@ test/tb_length_prefixed_frame_ring_top.sv @@
`timescale 1ns / 1ps
module tb_length_prefixed_frame_ring_top;
	import lpfr_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  kind = '0;
	logic [15:0] frame_length = '0;
	logic [7:0]  data_byte = '0;
	logic [15:0] out_capacity = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic [11:0] read_length;
	logic [7:0]  read_byte;
	logic        last_byte;
	logic [12:0] used_bytes;
	logic [31:0] dropped_count;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [1:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	localparam logic [1:0] RING_BYTES_ADDR = 2'd0;

	length_prefixed_frame_ring_top i_dut (.*);

	always #1 clk = ~clk;

	// shadow of the ring state
	logic [7:0]  ring_mem [0:CAPACITY-1];
	int unsigned ring_cfg = CAPACITY;
	int unsigned wr_off, rd_off, occ, wr_cur, wr_left, rd_cur, rd_left, wr_len, rd_len;
	bit          wr_open, rd_open;
	logic [31:0] drops;

	result_t     pending_results [$];
	int          fail_count = 0;
	int          rx_count = 0;
	int          items_sent = 0;

	function automatic int unsigned ring_size();
		if (ring_cfg < 8) return 8;
		if (ring_cfg > CAPACITY) return CAPACITY;
		return ring_cfg;
	endfunction

	function automatic int unsigned next_pos(input int unsigned p);
		return (p + 1) % ring_size();
	endfunction

	function void empty_ring();
		wr_off = 0; rd_off = 0; occ = 0; wr_cur = 0; wr_left = 0;
		rd_cur = 0; rd_left = 0; wr_len = 0; rd_len = 0;
		wr_open = 0; rd_open = 0;
	endfunction

	// compute the result of one transfer and advance the shadow state
	function result_t ring_outcome(input logic [1:0] k, input logic [15:0] fl,
			input logic [7:0] db, input logic [15:0] oc);
		result_t r;
		int unsigned rs, pos, len;
		r = '0;
		rs = ring_size();
		r.status = ST_OK;
		case (k)
			K_BEGIN_WR: begin
				if (wr_open) r.status = ST_SEQ;
				else if (PREFIX + fl > rs || PREFIX + fl > (occ < rs ? rs - occ : 0)) begin
					r.status = ST_DROP;
					if (drops != 32'hFFFF_FFFF) drops++;
				end else begin
					pos = wr_off;
					for (int i = 0; i < PREFIX; i++) begin
						ring_mem[pos] = fl[8*i +: 8] & {8{i < 2}};
						pos = next_pos(pos);
					end
					wr_cur = pos; wr_left = fl; wr_len = fl;
					if (fl == 0) begin
						wr_off = wr_cur; occ += PREFIX; r.last_byte = 1'b1;
					end else wr_open = 1;
				end
			end
			K_WR_BYTE: begin
				if (!wr_open) r.status = ST_SEQ;
				else begin
					ring_mem[wr_cur] = db;
					wr_cur = next_pos(wr_cur);
					wr_left--;
					if (wr_left == 0) begin
						wr_off = wr_cur; occ += PREFIX + wr_len; wr_open = 0;
						r.last_byte = 1'b1;
					end
				end
			end
			K_BEGIN_RD: begin
				if (rd_open) r.status = ST_SEQ;
				else if (occ < PREFIX) r.status = ST_EMPTY;
				else begin
					len = 0;
					pos = rd_off;
					for (int i = 0; i < PREFIX; i++) begin
						len |= int'(ring_mem[pos]) << (8 * i);
						pos = next_pos(pos);
					end
					if (occ < PREFIX + len || oc < len) r.status = ST_NOFIT;
					else begin
						r.read_length = len[11:0];
						rd_cur = pos; rd_left = len; rd_len = len;
						if (len == 0) begin
							rd_off = rd_cur; occ -= PREFIX; r.last_byte = 1'b1;
						end else rd_open = 1;
					end
				end
			end
			default: begin
				if (!rd_open) r.status = ST_SEQ;
				else begin
					r.read_byte = ring_mem[rd_cur];
					rd_cur = next_pos(rd_cur);
					rd_left--;
					if (rd_left == 0) begin
						rd_off = rd_cur; occ -= PREFIX + rd_len; rd_open = 0;
						r.last_byte = 1'b1;
					end
				end
			end
		endcase
		r.used_bytes = occ[12:0];
		r.dropped_count = drops;
		return r;
	endfunction

	// offer one transfer, hold it until taken, then maybe leave a gap
	task automatic send(input logic [1:0] k, input logic [15:0] fl, input logic [7:0] db,
			input logic [15:0] oc, input bit typed = 0, input logic [2:0] typed_status = ST_OK);
		result_t r;
		int gap, p;
		in_valid <= 1'b1;
		kind <= k;
		frame_length <= fl;
		data_byte <= db;
		out_capacity <= oc;
		do @(posedge clk); while (in_stall);
		r = ring_outcome(k, fl, db, oc);
		if (typed) r.status = typed_status;
		pending_results.push_back(r);
		items_sent++;
		p = $urandom_range(0, 99);
		gap = p < 50 ? 0 : p < 90 ? $urandom_range(1, 3) : p < 98 ? $urandom_range(4, 10)
			: $urandom_range(20, 60);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// write ring_bytes once the block has gone quiet
	task automatic set_ring_bytes(input logic [31:0] v);
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (12) @(posedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= RING_BYTES_ADDR;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		ring_cfg = v & 32'h1FFF;
		empty_ring();
		@(posedge clk);
	endtask

	task automatic finish_write();
		while (wr_open) send(K_WR_BYTE, $urandom, $urandom, $urandom);
	endtask

	task automatic finish_read();
		while (rd_open) send(K_RD_BYTE, $urandom, $urandom, $urandom);
	endtask

	function automatic logic [15:0] pick_length();
		int unsigned rs, p;
		rs = ring_size();
		p = $urandom_range(0, 99);
		if (p < 10) return $urandom;
		if (p < 15) return rs <= 256 ? $urandom_range(0, rs) : $urandom_range(0, 600);
		return $urandom_range(0, rs < 40 ? rs : 40);
	endfunction

	typedef struct {
		logic [1:0]  k;
		logic [15:0] fl;
		logic [7:0]  db;
		logic [15:0] oc;
		bit          typed;
		logic [2:0]  st;
	} row_t;

	row_t directed_rows [] = '{
		'{K_BEGIN_RD, 16'h0, 8'h0, 16'hFFFF, 1, ST_EMPTY},
		'{K_RD_BYTE, 16'h0, 8'h0, 16'h0, 1, ST_SEQ},
		'{K_WR_BYTE, 16'hFFFF, 8'hFF, 16'hFFFF, 1, ST_SEQ},
		'{K_BEGIN_WR, 16'h0, 8'h0, 16'h0, 1, ST_OK},
		'{K_BEGIN_WR, 16'hFFFF, 8'h0, 16'h0, 1, ST_DROP},
		'{K_BEGIN_WR, 16'd4093, 8'h0, 16'h0, 1, ST_DROP},
		'{K_BEGIN_WR, 16'd3, 8'h0, 16'h0, 1, ST_OK},
		'{K_BEGIN_WR, 16'd1, 8'h0, 16'h0, 1, ST_SEQ},
		'{K_WR_BYTE, 16'h0, 8'h00, 16'h0, 0, ST_OK},
		'{K_WR_BYTE, 16'h0, 8'hFF, 16'h0, 0, ST_OK},
		'{K_WR_BYTE, 16'h0, 8'hA5, 16'h0, 0, ST_OK},
		'{K_BEGIN_RD, 16'h0, 8'h0, 16'h0, 1, ST_OK},
		'{K_BEGIN_RD, 16'h0, 8'h0, 16'd2, 1, ST_NOFIT},
		'{K_BEGIN_RD, 16'h0, 8'h0, 16'hFFFF, 1, ST_OK},
		'{K_BEGIN_RD, 16'h0, 8'h0, 16'hFFFF, 1, ST_SEQ},
		'{K_RD_BYTE, 16'h0, 8'h0, 16'h0, 0, ST_OK},
		'{K_RD_BYTE, 16'h0, 8'h0, 16'h0, 0, ST_OK},
		'{K_RD_BYTE, 16'h0, 8'h0, 16'h0, 0, ST_OK},
		'{K_BEGIN_RD, 16'h0, 8'h0, 16'h0, 1, ST_EMPTY}
	};

	logic [31:0] ring_settings [] = '{32'd0, 32'd8, 32'd37, 32'd8191, 32'd100, 32'd4096};

	// stimulus
	initial begin
		int p;
		for (int i = 0; i < CAPACITY; i++) ring_mem[i] = '0;
		empty_ring();
		drops = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[i])
			send(directed_rows[i].k, directed_rows[i].fl, directed_rows[i].db,
				directed_rows[i].oc, directed_rows[i].typed, directed_rows[i].st);
		foreach (ring_settings[s]) begin
			set_ring_bytes(ring_settings[s]);
			while (items_sent < (s + 1) * 300 + directed_rows.size()) begin
				p = $urandom_range(0, 99);
				if (p < 45) begin
					// frame write, sometimes cut short
					finish_write();
					send(K_BEGIN_WR, pick_length(), $urandom, $urandom);
					if (wr_open) begin
						int n;
						n = $urandom_range(0, 19) == 0 ? $urandom_range(0, wr_left - 1) : wr_left;
						repeat (n) send(K_WR_BYTE, $urandom, $urandom, $urandom);
					end
				end else if (p < 85) begin
					// frame read with a mostly roomy capacity
					finish_read();
					send(K_BEGIN_RD, $urandom, $urandom,
						$urandom_range(0, 99) < 15 ? $urandom_range(0, 20) : 16'hFFFF);
					if (rd_open && $urandom_range(0, 19) == 0)
						repeat ($urandom_range(0, rd_left - 1)) send(K_RD_BYTE, 0, 0, 0);
					else finish_read();
				end else begin
					send($urandom_range(0, 3), $urandom, $urandom, $urandom);
				end
			end
		end
		in_valid <= 1'b0;
		wait (pending_results.size() == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0) $display("[length_prefixed_frame_ring_top] OK");
		else $display("[length_prefixed_frame_ring_top] ERROR");
		$finish;
	end

	// receiver stalls, with one long hold-off to back up the block
	initial begin
		int p;
		bit held;
		held = 0;
		forever begin
			if (!held && rx_count >= 300) begin
				held = 1;
				out_stall <= 1'b1;
				repeat (400) @(posedge clk);
			end else begin
				p = $urandom_range(0, 99);
				if (p < 40) begin
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 40)) @(posedge clk);
				end else if (p < 95) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					out_stall <= 1'b1;
					repeat ($urandom_range(10, 50)) @(posedge clk);
				end
			end
		end
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		result_t e;
		if (out_valid && !out_stall) begin
			rx_count++;
			if (pending_results.size() == 0) begin
				$error("unexpected result transfer");
				fail_count++;
			end else begin
				e = pending_results.pop_front();
				if (status !== e.status) begin
					$error("status expected %0d got %0d", e.status, status); fail_count++;
				end
				if (read_length !== e.read_length) begin
					$error("read_length expected %0d got %0d", e.read_length, read_length);
					fail_count++;
				end
				if (read_byte !== e.read_byte) begin
					$error("read_byte expected %0h got %0h", e.read_byte, read_byte); fail_count++;
				end
				if (last_byte !== e.last_byte) begin
					$error("last_byte expected %0d got %0d", e.last_byte, last_byte); fail_count++;
				end
				if (used_bytes !== e.used_bytes) begin
					$error("used_bytes expected %0d got %0d", e.used_bytes, used_bytes);
					fail_count++;
				end
				if (dropped_count !== e.dropped_count) begin
					$error("dropped_count expected %0d got %0d", e.dropped_count, dropped_count);
					fail_count++;
				end
			end
		end
	end

	// run limit
	initial begin
		#2000000;
		$display("[length_prefixed_frame_ring_top] ERROR");
		$finish;
	end
endmodule
